### hdl/cpsf_pkg.sv
package cpsf_pkg;

  // Configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 33;

  localparam logic [CFG_IDX_W-1:0] CFG_LOG2_W  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LOG2_H  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TRUST   = 2'd2;

  // Register and field widths
  localparam int LOG_W     = 4;
  localparam int THR_W     = 33;
  localparam int SHIFT_W   = 13;
  localparam int RATIO_W   = 48;
  localparam int FRAC_BITS = 16;

  localparam logic [LOG_W-1:0] LOG2_RESET  = 4'd6;
  localparam logic [THR_W-1:0] TRUST_RESET = '0;

  // Controller to datapath
  typedef struct packed {
    logic acc_en;      // a sample transaction is taken
    logic frame_load;  // that sample closes the frame: capture totals
    logic div_prep;    // form numerator and denominator magnitudes
    logic div_step;    // one quotient bit
    logic out_load;    // format and load the result register
  } cpsf_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic frame_last;  // next sample closes the frame
    logic div_done;    // current divide step is the last one
  } cpsf_status_t;

endpackage

### hdl/cpsf_ctrl.sv
module cpsf_ctrl (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_stall,
  output logic                   out_valid,
  input  logic                   out_stall,
  input  cpsf_pkg::cpsf_status_t status,
  output cpsf_pkg::cpsf_cmd_t    cmd
);
  import cpsf_pkg::*;

  localparam logic [1:0] ST_ACC  = 2'd0;
  localparam logic [1:0] ST_PREP = 2'd1;
  localparam logic [1:0] ST_DIV  = 2'd2;
  localparam logic [1:0] ST_OUT  = 2'd3;

  logic [1:0] state_r;
  logic [1:0] state_nxt;
  logic       out_valid_r;
  logic       out_valid_nxt;
  logic       accept;

  // hold off input outside ST_ACC and the closing sample while a result waits
  assign in_stall = (state_r != ST_ACC) || (out_valid_r && status.frame_last);
  assign accept   = in_valid && !in_stall;

  always_comb begin
    cmd.acc_en     = accept;
    cmd.frame_load = accept && status.frame_last;
    cmd.div_prep   = (state_r == ST_PREP);
    cmd.div_step   = (state_r == ST_DIV);
    cmd.out_load   = (state_r == ST_OUT);
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_ACC: begin
        if (cmd.frame_load) begin
          state_nxt = ST_PREP;
        end
      end
      ST_PREP: begin
        state_nxt = ST_DIV;
      end
      ST_DIV: begin
        if (status.div_done) begin
          state_nxt = ST_OUT;
        end
      end
      ST_OUT: begin
        state_nxt = ST_ACC;
      end
      default: begin
        state_nxt = ST_ACC;
      end
    endcase
  end

  assign out_valid_nxt = cmd.out_load || (out_valid_r && out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_ACC;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule

### hdl/cpsf_dp.sv
module cpsf_dp #(
  parameter int MAX_LOG2_SIDE = 13,
  parameter int SAMPLE_BITS   = 32
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 cfg_we,
  input  logic [cpsf_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [cpsf_pkg::CFG_DATA_W-1:0]      cfg_data,
  input  logic signed [SAMPLE_BITS-1:0]        in_sample,
  input  cpsf_pkg::cpsf_cmd_t                  cmd,
  output cpsf_pkg::cpsf_status_t               status,
  output logic signed [cpsf_pkg::SHIFT_W-1:0]  out_shift_x,
  output logic signed [cpsf_pkg::SHIFT_W-1:0]  out_shift_y,
  output logic signed [cpsf_pkg::RATIO_W-1:0]  out_peak_ratio,
  output logic                                 out_distrust,
  output logic                                 out_big_shift_x,
  output logic                                 out_big_shift_y
);
  import cpsf_pkg::*;

  localparam int IDX_W  = 2 * MAX_LOG2_SIDE;
  localparam int CNT_W  = IDX_W + 1;
  localparam int SUM_W  = SAMPLE_BITS + IDX_W;
  localparam int NUM_W  = SAMPLE_BITS + IDX_W + FRAC_BITS;
  localparam int DEN_W  = SUM_W;
  localparam int STEP_W = $clog2(NUM_W);
  localparam int SH_W   = $clog2(IDX_W + FRAC_BITS + 1);
  localparam int XW     = MAX_LOG2_SIDE + 1;

  localparam logic [LOG_W-1:0]   MAX_LOG = LOG_W'(MAX_LOG2_SIDE);
  localparam logic [RATIO_W-1:0] LIMIT   = {1'b1, {(RATIO_W-1){1'b0}}};

  // ---------------- configuration registers ----------------
  logic [LOG_W-1:0] cfg_lw_r;
  logic [LOG_W-1:0] cfg_lh_r;
  logic [THR_W-1:0] cfg_thr_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_lw_r  <= LOG2_RESET;
      cfg_lh_r  <= LOG2_RESET;
      cfg_thr_r <= TRUST_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_LOG2_W: cfg_lw_r  <= cfg_data[LOG_W-1:0];
        CFG_LOG2_H: cfg_lh_r  <= cfg_data[LOG_W-1:0];
        CFG_TRUST:  cfg_thr_r <= cfg_data[THR_W-1:0];
        default: ;
      endcase
    end
  end

  logic [LOG_W-1:0] lw;
  logic [LOG_W-1:0] lh;

  always_comb begin
    lw = cfg_lw_r;
    if (cfg_lw_r == '0) begin
      lw = LOG_W'(1);
    end else if (cfg_lw_r > MAX_LOG) begin
      lw = MAX_LOG;
    end
    lh = cfg_lh_r;
    if (cfg_lh_r == '0) begin
      lh = LOG_W'(1);
    end else if (cfg_lh_r > MAX_LOG) begin
      lh = MAX_LOG;
    end
  end

  // ---------------- accumulation ----------------
  logic [IDX_W-1:0]              cnt_r;
  logic signed [SAMPLE_BITS-1:0] best_r;
  logic [IDX_W-1:0]              idx_r;
  logic signed [SUM_W-1:0]       sum_r;

  logic [LOG_W:0]                lsum;
  logic [CNT_W-1:0]              total;
  logic [CNT_W-1:0]              cnt_inc;
  logic                          first;
  logic                          best_upd;
  logic signed [SAMPLE_BITS-1:0] best_nxt;
  logic [IDX_W-1:0]              idx_nxt;
  logic signed [SUM_W-1:0]       sum_nxt;

  assign lsum    = {1'b0, lw} + {1'b0, lh};
  assign total   = CNT_W'(1) << lsum;
  assign cnt_inc = {1'b0, cnt_r} + CNT_W'(1);
  assign status.frame_last = (cnt_inc >= total);

  assign first    = (cnt_r == '0);
  assign best_upd = first || (in_sample > best_r);
  assign best_nxt = best_upd ? in_sample : best_r;
  assign idx_nxt  = first ? '0 : (best_upd ? cnt_r : idx_r);
  assign sum_nxt  = first ? SUM_W'(in_sample) : sum_r + SUM_W'(in_sample);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (cmd.acc_en) begin
      cnt_r <= cmd.frame_load ? '0 : cnt_inc[IDX_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.acc_en) begin
      best_r <= best_nxt;
      idx_r  <= idx_nxt;
      sum_r  <= sum_nxt;
    end
  end

  // ---------------- frame capture ----------------
  logic signed [SAMPLE_BITS-1:0] cap_peak_r;
  logic signed [SUM_W-1:0]       cap_sum_r;
  logic [IDX_W-1:0]              cap_idx_r;
  logic [LOG_W-1:0]              cap_lw_r;
  logic [LOG_W-1:0]              cap_lh_r;
  logic [THR_W-1:0]              cap_thr_r;

  always_ff @(posedge clk) begin
    if (cmd.frame_load) begin
      cap_peak_r <= best_nxt;
      cap_sum_r  <= sum_nxt;
      cap_idx_r  <= idx_nxt;
      cap_lw_r   <= lw;
      cap_lh_r   <= lh;
      cap_thr_r  <= cfg_thr_r;
    end
  end

  // ---------------- restoring divider, one bit per cycle ----------------
  logic [SAMPLE_BITS-1:0] pmag;
  logic [SH_W-1:0]        sh;
  logic [NUM_W-1:0]       num_init;
  logic [DEN_W-1:0]       den_init;

  assign pmag     = cap_peak_r[SAMPLE_BITS-1] ? SAMPLE_BITS'(-cap_peak_r)
                                               : SAMPLE_BITS'(cap_peak_r);
  assign sh       = SH_W'(cap_lw_r) + SH_W'(cap_lh_r) + SH_W'(FRAC_BITS);
  assign num_init = NUM_W'(pmag) << sh;
  assign den_init = cap_sum_r[SUM_W-1] ? DEN_W'(-cap_sum_r) : DEN_W'(cap_sum_r);

  logic [NUM_W-1:0]   num_r;
  logic [DEN_W-1:0]   den_r;
  logic [DEN_W-1:0]   rem_r;
  logic [RATIO_W-1:0] q_r;
  logic               ovf_r;
  logic               neg_r;
  logic               zero_r;
  logic [STEP_W-1:0]  step_r;

  logic [DEN_W:0]     trial;
  logic [DEN_W:0]     diff;
  logic               ge;
  logic [DEN_W-1:0]   rem_nxt;

  assign trial   = {rem_r, num_r[NUM_W-1]};
  assign diff    = trial - {1'b0, den_r};
  assign ge      = (trial >= {1'b0, den_r});
  assign rem_nxt = ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
  assign status.div_done = (step_r == '0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= '0;
    end else if (cmd.div_prep) begin
      step_r <= STEP_W'(NUM_W - 1);
    end else if (cmd.div_step) begin
      step_r <= step_r - STEP_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.div_prep) begin
      num_r  <= num_init;
      den_r  <= den_init;
      rem_r  <= '0;
      q_r    <= '0;
      ovf_r  <= 1'b0;
      neg_r  <= cap_peak_r[SAMPLE_BITS-1] ^ cap_sum_r[SUM_W-1];
      zero_r <= (cap_sum_r == '0);
    end else if (cmd.div_step) begin
      num_r  <= num_r << 1;
      rem_r  <= rem_nxt;
      ovf_r  <= ovf_r | q_r[RATIO_W-1];
      q_r    <= {q_r[RATIO_W-2:0], ge};
    end
  end

  // ---------------- result formatting ----------------
  logic                       sat;
  logic [RATIO_W-1:0]         mag;
  logic signed [RATIO_W-1:0]  ratio;
  logic signed [RATIO_W:0]    ratio_x;
  logic signed [RATIO_W:0]    thr_x;

  assign sat   = ovf_r || (q_r > LIMIT);
  assign mag   = sat ? LIMIT : q_r;

  always_comb begin
    if (zero_r) begin
      ratio = '0;
    end else if (neg_r) begin
      ratio = -mag;
    end else if (mag == LIMIT) begin
      ratio = LIMIT - RATIO_W'(1);
    end else begin
      ratio = mag;
    end
  end

  assign ratio_x = (RATIO_W+1)'(ratio);
  assign thr_x   = (RATIO_W+1)'(cap_thr_r);

  function automatic logic signed [XW-1:0] wrap_shift(input logic [XW-1:0] pos,
                                                      input logic [XW-1:0] size);
    if (pos >= (size >> 1)) begin
      wrap_shift = signed'(pos - size);
    end else begin
      wrap_shift = signed'(pos);
    end
  endfunction

  function automatic logic is_big(input logic signed [XW-1:0] s,
                                  input logic [XW-1:0] size);
    logic [XW-1:0] a;
    a = s[XW-1] ? XW'(-s) : XW'(s);
    is_big = (a > (size >> 2));
  endfunction

  logic [XW-1:0]        size_x;
  logic [XW-1:0]        size_y;
  logic [XW-1:0]        col;
  logic [XW-1:0]        row;
  logic [IDX_W-1:0]     row_full;
  logic signed [XW-1:0] sx;
  logic signed [XW-1:0] sy;

  assign size_x   = XW'(1) << cap_lw_r;
  assign size_y   = XW'(1) << cap_lh_r;
  assign col      = XW'(cap_idx_r) & (size_x - XW'(1));
  assign row_full = cap_idx_r >> cap_lw_r;
  assign row      = XW'(row_full) & (size_y - XW'(1));
  assign sx       = wrap_shift(col, size_x);
  assign sy       = wrap_shift(row, size_y);

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_shift_x     <= SHIFT_W'(sx);
      out_shift_y     <= SHIFT_W'(sy);
      out_peak_ratio  <= ratio;
      out_distrust    <= (ratio_x < thr_x);
      out_big_shift_x <= is_big(sx, size_x);
      out_big_shift_y <= is_big(sy, size_y);
    end
  end

endmodule

### hdl/correlation_peak_shift_finder.sv
// Correlation peak shift finder. Feed the samples of a correlation surface
// of 2^log2_window_width columns by 2^log2_window_height rows in row-major
// order, one per transaction on the in_ channel. While a frame streams in,
// one sample is taken every cycle: the first strict maximum, its index and
// the signed running sum advance in a single step. The sample that closes
// the frame starts the peak-to-mean divide, a restoring divider that
// retires one quotient bit per cycle over SAMPLE_BITS + 2*MAX_LOG2_SIDE + 16
// numerator bits; the input is held off through the divide setup, the divide
// steps and the result load after each frame. The closing sample of a frame
// is also held while the previous result still waits on out_stall; all other
// samples flow regardless of the output side. Each frame yields one result
// transaction: the peak column and row as signed shifts, the ratio
// peak * W * H / sum in signed 32.16, saturated and zero for a zero sum,
// and flags for a ratio below trust_threshold and for shifts beyond a
// quarter of the window. Log2 settings of zero act as one, and settings
// above MAX_LOG2_SIDE act as MAX_LOG2_SIDE. Write configuration only while
// the block is idle.
module correlation_peak_shift_finder #(
  parameter int MAX_LOG2_SIDE = 13,
  parameter int SAMPLE_BITS   = 32
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  // configuration write port
  input  logic                                 cfg_we,
  input  logic [cpsf_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [cpsf_pkg::CFG_DATA_W-1:0]      cfg_data,
  // sample channel
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic signed [SAMPLE_BITS-1:0]        in_sample,
  // result channel
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic signed [cpsf_pkg::SHIFT_W-1:0]  out_shift_x,
  output logic signed [cpsf_pkg::SHIFT_W-1:0]  out_shift_y,
  output logic signed [cpsf_pkg::RATIO_W-1:0]  out_peak_ratio,
  output logic                                 out_distrust,
  output logic                                 out_big_shift_x,
  output logic                                 out_big_shift_y
);
  import cpsf_pkg::*;

  cpsf_cmd_t    cmd;
  cpsf_status_t status;

  // sequencing: accumulate, divide setup, divide steps, load result
  cpsf_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status    (status),
    .cmd       (cmd)
  );

  // accumulators, frame capture, divider and result register
  cpsf_dp #(
    .MAX_LOG2_SIDE (MAX_LOG2_SIDE),
    .SAMPLE_BITS   (SAMPLE_BITS)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .in_sample       (in_sample),
    .cmd             (cmd),
    .status          (status),
    .out_shift_x     (out_shift_x),
    .out_shift_y     (out_shift_y),
    .out_peak_ratio  (out_peak_ratio),
    .out_distrust    (out_distrust),
    .out_big_shift_x (out_big_shift_x),
    .out_big_shift_y (out_big_shift_y)
  );

endmodule

### hdl/cpsf_chk.sv
module cpsf_chk (
  input logic                                 clk,
  input logic                                 rst_n,
  input logic                                 out_valid,
  input logic                                 out_stall,
  input logic signed [cpsf_pkg::SHIFT_W-1:0]  out_shift_x,
  input logic signed [cpsf_pkg::SHIFT_W-1:0]  out_shift_y,
  input logic signed [cpsf_pkg::RATIO_W-1:0]  out_peak_ratio,
  input logic                                 out_distrust,
  input logic                                 out_big_shift_x,
  input logic                                 out_big_shift_y
);
  import cpsf_pkg::*;

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_peak_ratio)
      && $stable(out_shift_x) && $stable(out_shift_y))
    else $error("stalled result changed or dropped");

  // no result right after reset
  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // a negative ratio is always below a non-negative threshold
  a_neg_ratio_low: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_peak_ratio[RATIO_W-1] |-> out_distrust)
    else $error("negative ratio not flagged below threshold");

  // a zero shift is never large
  a_zero_shift: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_shift_x != '0 || !out_big_shift_x)
      && (out_shift_y != '0 || !out_big_shift_y))
    else $error("zero shift flagged large");

endmodule

bind correlation_peak_shift_finder cpsf_chk u_cpsf_chk (
  .clk             (clk),
  .rst_n           (rst_n),
  .out_valid       (out_valid),
  .out_stall       (out_stall),
  .out_shift_x     (out_shift_x),
  .out_shift_y     (out_shift_y),
  .out_peak_ratio  (out_peak_ratio),
  .out_distrust    (out_distrust),
  .out_big_shift_x (out_big_shift_x),
  .out_big_shift_y (out_big_shift_y)
);

### dv/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
  import cpsf_pkg::*;

  localparam int SIDE_LOG_MAX = 13;
  localparam int CYCLE_LIMIT  = 1_000_000;
  // Margin over the divider busy time after a frame closes.
  localparam int SETTLE_CYCLES = 100;
  // Long receiver hold-off, well past one divide, so the block backs up.
  localparam int HOLD_CYCLES = 400;
  localparam int WIDE_FRAME = 64;
  localparam int TALL_FRAME = 16;

  // One frame report, in the same field order as the result ports.
  typedef struct packed {
    logic signed [SHIFT_W-1:0] shift_x;
    logic signed [SHIFT_W-1:0] shift_y;
    logic signed [RATIO_W-1:0] peak_ratio;
    logic                      distrust;
    logic                      big_shift_x;
    logic                      big_shift_y;
  } peak_report_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic signed [31:0]    in_sample = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic signed [SHIFT_W-1:0] out_shift_x;
  logic signed [SHIFT_W-1:0] out_shift_y;
  logic signed [RATIO_W-1:0] out_peak_ratio;
  logic                  out_distrust;
  logic                  out_big_shift_x;
  logic                  out_big_shift_y;

  correlation_peak_shift_finder DUT (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_sample       (in_sample),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_shift_x     (out_shift_x),
    .out_shift_y     (out_shift_y),
    .out_peak_ratio  (out_peak_ratio),
    .out_distrust    (out_distrust),
    .out_big_shift_x (out_big_shift_x),
    .out_big_shift_y (out_big_shift_y)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 0;
  end

  // Mirror of the block's registers and frame state, advanced on every
  // accepted transaction. Reset values match the block after reset.
  logic [LOG_W-1:0]   log2_w_reg = LOG2_RESET;
  logic [LOG_W-1:0]   log2_h_reg = LOG2_RESET;
  logic [THR_W-1:0]   trust_reg = TRUST_RESET;
  logic [25:0]        frame_fill = '0;
  logic signed [31:0] peak_val = '0;
  logic [25:0]        peak_at = '0;
  logic signed [63:0] surface_sum = '0;

  peak_report_t pending_reports[$];
  int           mismatches = 0;
  int           cycle_count = 0;

  // Sender and receiver pacing, in percent of cycles spent idle.
  int sender_gap_pct = 28;
  int receiver_gap_pct = 67;
  int hold_asked = 0;
  int hold_served = 0;
  int hold_left = 0;

  // Directed rows can carry a hand-computed report for the closing sample.
  bit           pinned_due = 1'b0;
  peak_report_t pinned_report = '0;

  logic [31:0]  dir_samples [24];
  peak_report_t dir_reports [6];

  // Out-of-range side settings: zero acts as one, anything above the
  // largest side acts as the largest side.
  function automatic int unsigned side_log(input logic [LOG_W-1:0] v);
    if (v < 4'd1) return 1;
    if (v > 4'(SIDE_LOG_MAX)) return SIDE_LOG_MAX;
    return int'(v);
  endfunction

  // Peak over mean as signed 32.16: |peak| * 2^(lg+16) / |total|, truncated
  // toward zero, then clipped to the 48-bit signed range. Zero total gives 0.
  function automatic logic signed [63:0] mean_ratio(input logic signed [31:0] peak,
                                                    input logic signed [63:0] total,
                                                    input int unsigned lg);
    logic signed [63:0] wide_peak;
    logic [63:0]        num_mag;
    logic [63:0]        den_mag;
    logic [127:0]       quo;
    logic [127:0]       cap;
    bit                 neg;
    if (total == 0) return '0;
    wide_peak = peak;
    num_mag = wide_peak[63] ? -wide_peak : wide_peak;
    den_mag = total[63] ? -total : total;
    neg = wide_peak[63] ^ total[63];
    quo = ({64'd0, num_mag} << (lg + FRAC_BITS)) / {64'd0, den_mag};
    cap = 128'd1 << (RATIO_W - 1);
    if (quo > cap) quo = cap;
    if (neg) return -$signed(quo[63:0]);
    if (quo == cap) quo = cap - 1;
    return $signed(quo[63:0]);
  endfunction

  // Fold one sample into the frame. The frame closes once the fill reaches
  // the current window size, which also covers a window that shrank while
  // a frame was in flight.
  task automatic fold_sample(input logic signed [31:0] s, output bit closed,
                             output peak_report_t rep);
    int unsigned        lw;
    int unsigned        lh;
    int                 w;
    int                 h;
    int                 col;
    int                 row;
    int                 sx;
    int                 sy;
    logic signed [63:0] ratio;
    closed = 1'b0;
    rep = '0;
    lw = side_log(log2_w_reg);
    lh = side_log(log2_h_reg);
    if (frame_fill == '0) begin
      peak_val = s;
      peak_at = '0;
      surface_sum = s;
    end else begin
      surface_sum = surface_sum + s;
      // Strict compare: ties keep the earliest index.
      if (s > peak_val) begin
        peak_val = s;
        peak_at = frame_fill;
      end
    end
    frame_fill = frame_fill + 26'd1;
    if (frame_fill != '0 && 64'(frame_fill) < (64'd1 << (lw + lh))) return;

    w = 1 << lw;
    h = 1 << lh;
    col = int'(peak_at) & (w - 1);
    row = int'(peak_at >> lw) & (h - 1);
    sx = (col < w / 2) ? col : col - w;
    sy = (row < h / 2) ? row : row - h;
    ratio = mean_ratio(peak_val, surface_sum, lw + lh);
    rep.shift_x = SHIFT_W'(sx);
    rep.shift_y = SHIFT_W'(sy);
    rep.peak_ratio = ratio[RATIO_W-1:0];
    rep.distrust = ratio < $signed({31'd0, trust_reg});
    rep.big_shift_x = ((sx < 0) ? -sx : sx) > w / 4;
    rep.big_shift_y = ((sy < 0) ? -sy : sy) > h / 4;
    closed = 1'b1;
    frame_fill = '0;
    peak_val = '0;
    peak_at = '0;
    surface_sum = '0;
  endtask

  task automatic check_field(input string name, input logic signed [63:0] want,
                             input logic signed [63:0] got);
    if (want !== got) begin
      $error("%s mismatch: expected %0d, actual %0d", name, want, got);
      mismatches++;
    end
  endtask

  // Watch both channels and the register port at the rising edge. Mirror
  // register writes, predict on every accepted sample transaction, and
  // compare every accepted result transaction against the oldest report.
  always @(posedge clk) begin
    bit           closed;
    peak_report_t rep;
    peak_report_t want;
    if (rst_n) begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_LOG2_W: log2_w_reg = cfg_data[LOG_W-1:0];
          CFG_LOG2_H: log2_h_reg = cfg_data[LOG_W-1:0];
          CFG_TRUST:  trust_reg = cfg_data[THR_W-1:0];
          default: ;
        endcase
      end
      if (in_valid && !in_stall) begin
        fold_sample(in_sample, closed, rep);
        if (closed) pending_reports.push_back(pinned_due ? pinned_report : rep);
      end
      if (out_valid && !out_stall) begin
        if (pending_reports.size() == 0) begin
          $error("result transaction with no report pending: shift_x %0d shift_y %0d",
                 out_shift_x, out_shift_y);
          mismatches++;
        end else begin
          want = pending_reports.pop_front();
          check_field("shift_x", want.shift_x, out_shift_x);
          check_field("shift_y", want.shift_y, out_shift_y);
          check_field("peak_ratio", want.peak_ratio, out_peak_ratio);
          check_field("distrust", want.distrust, out_distrust);
          check_field("big_shift_x", want.big_shift_x, out_big_shift_x);
          check_field("big_shift_y", want.big_shift_y, out_big_shift_y);
        end
      end
    end
  end

  // Receiver: random stalls, or a long hold-off when the stimulus asks for
  // one. The hold-off is counted here so it runs on its own clock.
  always @(negedge clk) begin
    if (hold_left != 0) begin
      hold_left = hold_left - 1;
      out_stall <= 1'b1;
    end else if (hold_served != hold_asked) begin
      hold_served = hold_served + 1;
      hold_left = HOLD_CYCLES - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < receiver_gap_pct);
    end
  end

  // Guard against a hang.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // Offer one sample transaction and hold it until accepted. Random gaps
  // go in front with valid low; valid is raised only once per step.
  task automatic push_sample(input logic [31:0] value, input bit pin = 1'b0,
                             input peak_report_t pinned = '0);
    @(negedge clk);
    while ($urandom_range(99) < sender_gap_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_sample <= value;
    pinned_due = pin;
    pinned_report = pinned;
    do @(posedge clk); while (in_stall);
  endtask

  // Stop offering, wait for every pending report, then let the divider
  // settle in case a partial frame is still in flight.
  task automatic drain_results();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_reports.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // Write all three registers, one per cycle, with write enable held high
  // across the burst. Junk above the 4-bit side fields must be dropped.
  task automatic program_window(input logic [LOG_W-1:0] lw, input logic [LOG_W-1:0] lh,
                                input logic [THR_W-1:0] thr);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= CFG_LOG2_W;
    cfg_data <= {29'($urandom()), lw};
    @(negedge clk);
    cfg_index <= CFG_LOG2_H;
    cfg_data <= {29'($urandom()), lh};
    @(negedge clk);
    cfg_index <= CFG_TRUST;
    cfg_data <= thr;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // Mix of full-range values, small values that tie and cancel, zeros, the
  // two extremes of the sample field and values from 0 to 1000.
  function automatic logic [31:0] surface_value();
    case ($urandom_range(9))
      0, 1, 2:    return $urandom();
      3, 4, 5, 6: return 32'(int'($urandom_range(20)) - 10);
      7:          return 32'd0;
      8:          return $urandom_range(1) ? 32'h8000_0000 : 32'h7FFF_FFFF;
      default:    return $urandom_range(1000);
    endcase
  endfunction

  initial begin
    int unsigned      lw;
    int unsigned      lh;
    logic [THR_W-1:0] thr;

    // 2x2 window, threshold 1.0: each group of four is one frame.
    dir_samples = '{
      // flat surface: ratio exactly at threshold
      32'd5, 32'd5, 32'd5, 32'd5,
      // all zero: zero sum
      32'd0, 32'd0, 32'd0, 32'd0,
      // extremes, tie on the maximum, negative overflow
      32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
      // peak in the last cell, both shifts wrap
      32'd0, 32'd0, 32'd0, 32'd7,
      // sum of one: positive overflow
      32'h7FFF_FFFF, 32'h8000_0001, 32'd1, 32'd0,
      // positive peak over a negative sum
      32'hFFFF_FF9C, 32'd1, 32'hFFFF_FF9C, 32'hFFFF_FF9C
    };
    dir_reports = '{
      '{13'sd0, 13'sd0, 48'sd65536, 1'b0, 1'b0, 1'b0},
      '{13'sd0, 13'sd0, 48'sd0, 1'b1, 1'b0, 1'b0},
      '{-13'sd1, 13'sd0, 48'sh8000_0000_0000, 1'b1, 1'b1, 1'b0},
      '{-13'sd1, -13'sd1, 48'sd262144, 1'b0, 1'b1, 1'b1},
      '{13'sd0, 13'sd0, 48'sh7FFF_FFFF_FFFF, 1'b0, 1'b0, 1'b0},
      '{-13'sd1, 13'sd0, -48'sd876, 1'b1, 1'b1, 1'b0}
    };

    repeat (8) @(negedge clk);
    rst_n <= 1'b1;

    program_window(4'd1, 4'd1, 33'd65536);
    for (int i = 0; i < 24; i++) begin
      push_sample(dir_samples[i], (i % 4) == 3, dir_reports[i / 4]);
    end
    drain_results();

    // Wide window, height setting of zero: peak planted so the column
    // shift lands on the top of its range.
    program_window(4'd5, 4'd0, 33'd6553600000);
    for (int i = 0; i < WIDE_FRAME; i++) begin
      push_sample(i == 32 + 15 ? 32'h0010_0000 : 32'(int'($urandom_range(2000)) - 1000));
    end
    drain_results();

    // Width setting of zero, tall window: the row shift lands on the bottom.
    program_window(4'd0, 4'd3, '0);
    for (int i = 0; i < TALL_FRAME; i++) begin
      push_sample(i == 2 * 4 ? 32'h0010_0000 : 32'(int'($urandom_range(2000)) - 1000));
    end
    drain_results();

    // Random frames. Phases rarely end on a frame boundary, so the next
    // window setting lands mid-frame.
    for (int ph = 0; ph < 15; ph++) begin
      if (ph == 5) begin
        sender_gap_pct = 67;
        receiver_gap_pct = 28;
      end
      if (ph == 10) begin
        sender_gap_pct = 0;
        receiver_gap_pct = 0;
      end
      lw = $urandom_range(ph % 5 == 4 ? 3 : 2);
      lh = $urandom_range(ph % 5 == 4 ? 3 : 2);
      case (ph % 4)
        0:       thr = '0;
        1:       thr = 33'd6553600000;
        2:       thr = '1;
        default: thr = 33'($urandom_range(4 * 65536));
      endcase
      // Small frames under a long hold-off: the closing sample backs up.
      if (ph == 10) begin
        lw = 1;
        lh = 1;
      end
      program_window(4'(lw), 4'(lh), thr);
      if (ph == 10) hold_asked++;
      repeat (45) push_sample(surface_value());
      drain_results();
    end

    if (mismatches == 0 && pending_reports.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
